[hdl/dns_pkg.sv]
// Package with the types, constants and character codes of the decimal numeral scanner.
package dns_pkg;

    localparam int DIGITS       = 20;
    localparam int CAPACITY     = (DIGITS < 20) ? DIGITS : 20;
    localparam int HELD_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int HALF_DIGITS  = 10;
    localparam int HALF_W       = 4 * HALF_DIGITS;
    localparam int EXP_W        = 15;
    localparam int EXP_MUL_W    = EXP_W + 4;
    localparam int POS_W        = 15;
    localparam int CNT_W        = 16;
    localparam int POW_W        = 16;
    localparam int POW_CALC_W   = 18;
    localparam int COUNT_W      = 5;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_POINT     = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_LOWER_BIT = 8'h20;

    localparam logic [EXP_W-1:0] EXP_LIMIT = 15'd32767;
    localparam logic signed [POW_CALC_W-1:0] POW_MAX = 18'sd32767;
    localparam logic signed [POW_CALC_W-1:0] POW_MIN = -18'sd32767;

    typedef enum logic [5:0] {
        PH_BLANK = 6'b000001,
        PH_INT   = 6'b000010,
        PH_FRAC  = 6'b000100,
        PH_EXP   = 6'b001000,
        PH_ESIGN = 6'b010000,
        PH_EDIG  = 6'b100000
    } t_phase;

    typedef logic [CAPACITY-1:0][3:0] t_digits;

    typedef struct packed {
        t_phase             phase;
        logic               sign_seen;
        logic [HELD_W-1:0]  held;
        logic [CNT_W-1:0]   frac_cnt;
        logic [EXP_W-1:0]   exp_acc;
        logic               exp_neg;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   committed;
        logic               stopped;
        logic               stop_zero;
        logic               any_digit;
        logic [CNT_W-1:0]   dropped;
        logic               overflow;
        logic               exp_sat;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{phase: PH_BLANK, default: '0};

    typedef struct packed {
        logic                     negative;
        logic [COUNT_W-1:0]       digit_count;
        logic [HALF_W-1:0]        digits_first_ten;
        logic [HALF_W-1:0]        digits_last_ten;
        logic signed [POW_W-1:0]  power_of_ten;
        logic [POS_W-1:0]         accepted_length;
        logic                     not_a_number;
        logic                     reached_end;
        logic                     digits_overflow;
        logic                     exponent_clipped;
    } t_result;

endpackage

[hdl/dns_scan.sv]
// Scan state registers, digit store and the per-character next-state logic.
module dns_scan import dns_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_char,
    input  logic        i_end,
    output t_scan_state o_next,
    output t_digits     o_next_digits
);

    t_scan_state r_st;
    t_scan_state n_st;
    t_digits     r_digits;
    t_digits     n_digits;

    logic                 dig;
    logic                 is_e;
    logic                 is_sign;
    logic [3:0]           dval;
    logic [EXP_MUL_W-1:0] exp_mul;
    logic                 go_int;
    logic                 go_edig;
    logic                 mant;
    logic                 mant_frac;
    logic                 take_en;
    logic                 commit;
    logic                 halt;

    always_comb begin
        dig     = (i_char >= CH_ZERO) && (i_char <= CH_ZERO + 8'd9);
        is_e    = (i_char | CH_LOWER_BIT) == CH_E;
        is_sign = (i_char == CH_PLUS) || (i_char == CH_MINUS);
        dval    = dig ? 4'(i_char - CH_ZERO) : 4'd0;
        exp_mul = ({4'd0, r_st.exp_acc} << 3) + ({4'd0, r_st.exp_acc} << 1)
                + {{(EXP_MUL_W-4){1'b0}}, dval};

        n_st      = r_st;
        n_digits  = r_digits;
        go_int    = 1'b0;
        go_edig   = 1'b0;
        mant      = 1'b0;
        mant_frac = 1'b0;
        take_en   = 1'b0;
        commit    = 1'b0;
        halt      = 1'b0;

        if (!r_st.stopped) begin
            case (r_st.phase)
                PH_BLANK: begin
                    if ((i_char == CH_SPACE) || (i_char == CH_TAB)) begin
                        take_en = 1'b1;
                    end else if (is_sign) begin
                        n_st.sign_seen = (i_char == CH_MINUS);
                        n_st.phase     = PH_INT;
                        take_en        = 1'b1;
                    end else begin
                        go_int = 1'b1;
                    end
                end
                PH_INT: begin
                    go_int = 1'b1;
                end
                PH_FRAC: begin
                    if (dig) begin
                        mant      = 1'b1;
                        mant_frac = 1'b1;
                    end else if (is_e && r_st.any_digit) begin
                        n_st.phase = PH_EXP;
                        take_en    = 1'b1;
                    end else begin
                        halt = 1'b1;
                    end
                end
                PH_EXP: begin
                    if (is_sign) begin
                        n_st.exp_neg = (i_char == CH_MINUS);
                        n_st.phase   = PH_ESIGN;
                        take_en      = 1'b1;
                    end else begin
                        go_edig = 1'b1;
                    end
                end
                PH_ESIGN, PH_EDIG: begin
                    go_edig = 1'b1;
                end
                default: begin
                    halt = 1'b1;
                end
            endcase

            if (go_int) begin
                n_st.phase = PH_INT;
                if (dig) begin
                    mant = 1'b1;
                end else if (i_char == CH_POINT) begin
                    n_st.phase = PH_FRAC;
                    take_en    = 1'b1;
                    commit     = r_st.any_digit;
                end else if (is_e && r_st.any_digit) begin
                    n_st.phase = PH_EXP;
                    take_en    = 1'b1;
                end else begin
                    halt = 1'b1;
                end
            end

            if (go_edig) begin
                if (dig) begin
                    if (exp_mul > EXP_MUL_W'(EXP_LIMIT)) begin
                        n_st.exp_acc = EXP_LIMIT;
                        n_st.exp_sat = 1'b1;
                    end else begin
                        n_st.exp_acc = exp_mul[EXP_W-1:0];
                    end
                    n_st.phase = PH_EDIG;
                    take_en    = 1'b1;
                    commit     = 1'b1;
                end else begin
                    halt = 1'b1;
                end
            end

            if (mant) begin
                n_st.any_digit = 1'b1;
                take_en        = 1'b1;
                commit         = 1'b1;
                if ((r_st.held == '0) && (dval == 4'd0)) begin
                    if (mant_frac && (r_st.frac_cnt != '1)) begin
                        n_st.frac_cnt = r_st.frac_cnt + CNT_W'(1);
                    end
                end else if (r_st.held < HELD_W'(CAPACITY)) begin
                    n_digits[r_st.held[IDX_W-1:0]] = dval;
                    n_st.held = r_st.held + HELD_W'(1);
                    if (mant_frac && (r_st.frac_cnt != '1)) begin
                        n_st.frac_cnt = r_st.frac_cnt + CNT_W'(1);
                    end
                end else begin
                    n_st.overflow = 1'b1;
                    if (!mant_frac && (r_st.dropped != '1)) begin
                        n_st.dropped = r_st.dropped + CNT_W'(1);
                    end
                end
            end

            if (halt) begin
                n_st.stopped   = 1'b1;
                n_st.stop_zero = (i_char == CH_NUL);
            end

            if (take_en) begin
                if (r_st.position != '1) begin
                    n_st.position = r_st.position + POS_W'(1);
                end
                if (commit) begin
                    n_st.committed = n_st.position;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SCAN_RESET;
        end else if (i_step) begin
            r_st <= i_end ? SCAN_RESET : n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_digits <= n_digits;
        end
    end

    assign o_next        = n_st;
    assign o_next_digits = n_digits;

endmodule

[hdl/dns_format.sv]
// Builds the result record from the scan state: digit packing, exponent and flags.
module dns_format import dns_pkg::*; (
    input  t_scan_state i_st,
    input  t_digits     i_digits,
    output t_result     o_res
);

    logic [HALF_W-1:0]              first;
    logic [HALF_W-1:0]              second;
    logic signed [POW_CALC_W-1:0]   e_val;
    logic signed [POW_CALC_W-1:0]   pow;
    logic signed [POW_CALC_W-1:0]   pow_sat;
    logic                           edig;
    logic                           clipped;
    logic [COUNT_W-1:0]             count;

    always_comb begin
        first  = '0;
        second = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (HELD_W'(i) < i_st.held) begin
                if (i < HALF_DIGITS) begin
                    first[(HALF_DIGITS - 1 - i) * 4 +: 4] = i_digits[i];
                end else begin
                    second[(2 * HALF_DIGITS - 1 - i) * 4 +: 4] = i_digits[i];
                end
            end
        end

        edig = (i_st.phase == PH_EDIG);
        if (!edig) begin
            e_val = '0;
        end else if (i_st.exp_neg) begin
            e_val = -$signed({3'b000, i_st.exp_acc});
        end else begin
            e_val = $signed({3'b000, i_st.exp_acc});
        end
        pow = e_val - $signed({2'b00, i_st.frac_cnt}) + $signed({2'b00, i_st.dropped});

        clipped = i_st.exp_sat && edig;
        pow_sat = pow;
        if (pow > POW_MAX) begin
            pow_sat = POW_MAX;
            clipped = 1'b1;
        end else if (pow < POW_MIN) begin
            pow_sat = POW_MIN;
            clipped = 1'b1;
        end

        count = (i_st.held == '0) ? COUNT_W'(1) : COUNT_W'(i_st.held);

        o_res.negative     = i_st.sign_seen;
        o_res.not_a_number = !i_st.any_digit;
        o_res.reached_end  = !i_st.stopped || i_st.stop_zero;
        if (i_st.any_digit) begin
            o_res.digit_count      = count;
            o_res.digits_first_ten = first;
            o_res.digits_last_ten  = second;
            o_res.power_of_ten     = POW_W'(pow_sat);
            o_res.accepted_length  = i_st.committed;
            o_res.digits_overflow  = i_st.overflow;
            o_res.exponent_clipped = clipped;
        end else begin
            o_res.digit_count      = '0;
            o_res.digits_first_ten = '0;
            o_res.digits_last_ten  = '0;
            o_res.power_of_ten     = '0;
            o_res.accepted_length  = '0;
            o_res.digits_overflow  = 1'b0;
            o_res.exponent_clipped = 1'b0;
        end
    end

endmodule

[hdl/decimal_numeral_scanner.sv]
// Top level of the decimal numeral scanner: input register, scan core and result register.
//
//   Channel  Handshake                  Payload
//   input    i_in_valid / o_in_ready    i_char_code, i_end_of_text
//   output   o_out_valid / i_out_ready  o_negative ... o_exponent_clipped
//
// One character item is taken every cycle unless an end item waits to be scanned.
// A result is registered at the edge that scans its end item.
// Reset is synchronous and active low and returns the scanner to the blank phase.
// Only an end item waits in the input register while the result register is still full.
module decimal_numeral_scanner import dns_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_char_code,
    input  logic                    i_end_of_text,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_negative,
    output logic [COUNT_W-1:0]      o_digit_count,
    output logic [HALF_W-1:0]       o_digits_first_ten,
    output logic [HALF_W-1:0]       o_digits_last_ten,
    output logic signed [POW_W-1:0] o_power_of_ten,
    output logic [POS_W-1:0]        o_accepted_length,
    output logic                    o_not_a_number,
    output logic                    o_reached_end,
    output logic                    o_digits_overflow,
    output logic                    o_exponent_clipped
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_end;
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        step;
    t_scan_state scan_next;
    t_digits     scan_digits;
    t_result     fmt_res;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!r_in_end || out_free);
    assign o_in_ready = !r_in_valid || step;

    dns_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_char        (r_in_char),
        .i_end         (r_in_end),
        .o_next        (scan_next),
        .o_next_digits (scan_digits)
    );

    dns_format u_format (
        .i_st     (scan_next),
        .i_digits (scan_digits),
        .o_res    (fmt_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step && r_in_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_char_code;
            r_in_end  <= i_end_of_text;
        end
        if (step && r_in_end) begin
            r_out <= fmt_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_negative         = r_out.negative;
    assign o_digit_count      = r_out.digit_count;
    assign o_digits_first_ten = r_out.digits_first_ten;
    assign o_digits_last_ten  = r_out.digits_last_ten;
    assign o_power_of_ten     = r_out.power_of_ten;
    assign o_accepted_length  = r_out.accepted_length;
    assign o_not_a_number     = r_out.not_a_number;
    assign o_reached_end      = r_out.reached_end;
    assign o_digits_overflow  = r_out.digits_overflow;
    assign o_exponent_clipped = r_out.exponent_clipped;

    a_end_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_end) |=> r_out_valid)
        else $error("Scanned end item did not produce a result.");

    a_end_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_end && !out_free) |=> (r_in_valid && r_in_end))
        else $error("Blocked end item left the input register.");

    a_nan_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_not_a_number) |->
        (o_digit_count == '0 && o_accepted_length == '0 && o_power_of_ten == '0))
        else $error("Result without digits carries a number.");

    a_number_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_not_a_number) |-> (o_digit_count != '0))
        else $error("Result with digits has a zero digit count.");

endmodule

[test/decimal_numeral_scanner_tb.sv]
// Self-checking testbench for the decimal numeral scanner, with a predicting scoreboard.
module decimal_numeral_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dns_pkg::*;

    localparam int POS_LIMIT    = 32767;
    localparam int COUNT_LIMIT  = 65535;
    localparam int EXP_MAX      = 32767;
    localparam int POWER_LIMIT  = 32767;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_CHARS = 1550;

    typedef enum logic [1:0] {SEND_CHAR, SEND_MODE, SEND_HOLD, SEND_DRAIN} t_send_kind;
    typedef enum logic [1:0] {PACE_SINK_SLOW, PACE_SOURCE_SLOW, PACE_FULL} t_pace;

    typedef struct {
        t_send_kind kind;
        logic [7:0] code;
        logic       last;
    } t_send_entry;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [7:0]              i_char_code = 8'h00;
    logic                    i_end_of_text = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_negative;
    logic [COUNT_W-1:0]      o_digit_count;
    logic [HALF_W-1:0]       o_digits_first_ten;
    logic [HALF_W-1:0]       o_digits_last_ten;
    logic signed [POW_W-1:0] o_power_of_ten;
    logic [POS_W-1:0]        o_accepted_length;
    logic                    o_not_a_number;
    logic                    o_reached_end;
    logic                    o_digits_overflow;
    logic                    o_exponent_clipped;

    t_send_entry text_queue[$];
    t_result     records_due[$];
    int          chars_queued = 0;
    int          mismatches = 0;
    logic        in_taken = 1'b0;
    t_pace       pace = PACE_FULL;
    logic [7:0]  hold_token = 8'd0;
    logic [7:0]  hold_seen = 8'd0;
    int          hold_left = 0;

    t_phase      np_phase;
    logic        np_minus;
    logic [3:0]  np_digits [CAPACITY];
    int          np_held;
    int          np_frac;
    int          np_exp;
    logic        np_exp_neg;
    int          np_pos;
    int          np_committed;
    logic        np_stopped;
    logic        np_stop_zero;
    logic        np_any;
    int          np_dropped;
    logic        np_overflow;
    logic        np_exp_sat;

    decimal_numeral_scanner uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_char_code        (i_char_code),
        .i_end_of_text      (i_end_of_text),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_negative         (o_negative),
        .o_digit_count      (o_digit_count),
        .o_digits_first_ten (o_digits_first_ten),
        .o_digits_last_ten  (o_digits_last_ten),
        .o_power_of_ten     (o_power_of_ten),
        .o_accepted_length  (o_accepted_length),
        .o_not_a_number     (o_not_a_number),
        .o_reached_end      (o_reached_end),
        .o_digits_overflow  (o_digits_overflow),
        .o_exponent_clipped (o_exponent_clipped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void np_clear();
        np_phase     = PH_BLANK;
        np_minus     = 1'b0;
        np_held      = 0;
        np_frac      = 0;
        np_exp       = 0;
        np_exp_neg   = 1'b0;
        np_pos       = 0;
        np_committed = 0;
        np_stopped   = 1'b0;
        np_stop_zero = 1'b0;
        np_any       = 1'b0;
        np_dropped   = 0;
        np_overflow  = 1'b0;
        np_exp_sat   = 1'b0;
        foreach (np_digits[i]) np_digits[i] = 4'd0;
    endfunction

    function automatic void np_take(input logic commit);
        if (np_pos < POS_LIMIT) np_pos++;
        if (commit) np_committed = np_pos;
    endfunction

    function automatic void np_halt(input logic [7:0] c);
        np_stopped   = 1'b1;
        np_stop_zero = (c == CH_NUL);
    endfunction

    function automatic void np_mantissa(input logic [3:0] d, input logic frac);
        np_any = 1'b1;
        if (np_held == 0 && d == 4'd0) begin
            if (frac && np_frac < COUNT_LIMIT) np_frac++;
        end else if (np_held < CAPACITY) begin
            np_digits[np_held] = d;
            np_held++;
            if (frac && np_frac < COUNT_LIMIT) np_frac++;
        end else begin
            np_overflow = 1'b1;
            if (!frac && np_dropped < COUNT_LIMIT) np_dropped++;
        end
        np_take(1'b1);
    endfunction

    function automatic void np_scan(input logic [7:0] c);
        logic       dig;
        logic       is_e;
        logic [7:0] d;
        t_phase     ph;
        int         acc;
        dig  = (c >= CH_ZERO) && (c <= CH_ZERO + 8'd9);
        is_e = ((c | CH_LOWER_BIT) == CH_E);
        d    = c - CH_ZERO;
        if (np_stopped) return;
        ph = np_phase;
        if (ph == PH_BLANK) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                np_take(1'b0);
                return;
            end
            if (c == CH_PLUS || c == CH_MINUS) begin
                np_minus = (c == CH_MINUS);
                np_phase = PH_INT;
                np_take(1'b0);
                return;
            end
            np_phase = PH_INT;
            ph = PH_INT;
        end
        if (ph == PH_EXP && (c == CH_PLUS || c == CH_MINUS)) begin
            np_exp_neg = (c == CH_MINUS);
            np_phase = PH_ESIGN;
            np_take(1'b0);
            return;
        end
        case (ph)
            PH_INT: begin
                if (dig) np_mantissa(d[3:0], 1'b0);
                else if (c == CH_POINT) begin
                    np_phase = PH_FRAC;
                    np_take(np_any);
                end else if (is_e && np_any) begin
                    np_phase = PH_EXP;
                    np_take(1'b0);
                end else np_halt(c);
            end
            PH_FRAC: begin
                if (dig) np_mantissa(d[3:0], 1'b1);
                else if (is_e && np_any) begin
                    np_phase = PH_EXP;
                    np_take(1'b0);
                end else np_halt(c);
            end
            PH_EXP, PH_ESIGN, PH_EDIG: begin
                if (dig) begin
                    acc = np_exp * 10 + int'(d);
                    if (acc > EXP_MAX) begin
                        acc = EXP_MAX;
                        np_exp_sat = 1'b1;
                    end
                    np_exp = acc;
                    np_phase = PH_EDIG;
                    np_take(1'b1);
                end else np_halt(c);
            end
            default: np_halt(c);
        endcase
    endfunction

    function automatic t_result np_record();
        t_result r;
        int      power;
        int      i;
        r = '0;
        r.negative        = np_minus;
        r.accepted_length = POS_W'(np_committed);
        r.not_a_number    = !np_any;
        r.reached_end     = !np_stopped || np_stop_zero;
        if (np_any) begin
            r.digit_count = COUNT_W'((np_held == 0) ? 1 : np_held);
            for (i = 0; i < np_held; i++) begin
                if (i < HALF_DIGITS)
                    r.digits_first_ten[(HALF_DIGITS - 1 - i) * 4 +: 4] = np_digits[i];
                else
                    r.digits_last_ten[(2 * HALF_DIGITS - 1 - i) * 4 +: 4] = np_digits[i];
            end
            power = 0;
            if (np_phase == PH_EDIG) power = np_exp_neg ? -np_exp : np_exp;
            power = power - np_frac + np_dropped;
            r.exponent_clipped = np_exp_sat && (np_phase == PH_EDIG);
            if (power > POWER_LIMIT) begin
                power = POWER_LIMIT;
                r.exponent_clipped = 1'b1;
            end else if (power < -POWER_LIMIT) begin
                power = -POWER_LIMIT;
                r.exponent_clipped = 1'b1;
            end
            r.power_of_ten    = POW_W'(power);
            r.digits_overflow = np_overflow;
        end
        np_clear();
        return r;
    endfunction

    function automatic void report_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_text(input logic [7:0] chars[$]);
        t_send_entry e;
        foreach (chars[i]) begin
            e.kind = SEND_CHAR;
            e.code = chars[i];
            e.last = (i == chars.size() - 1);
            text_queue.push_back(e);
        end
        chars_queued += chars.size();
    endtask

    task automatic queue_string(input string s);
        logic [7:0] t[$];
        int         i;
        for (i = 0; i < s.len(); i++) t.push_back(s[i]);
        queue_text(t);
    endtask

    task automatic queue_marker(input t_send_kind kind, input logic [7:0] code);
        t_send_entry e;
        e.kind = kind;
        e.code = code;
        e.last = 1'b0;
        text_queue.push_back(e);
    endtask

    task automatic queue_random_text();
        logic [7:0] t[$];
        int         n;
        logic       zeros;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(255)));
        end else begin
            zeros = ($urandom_range(5) == 0);
            repeat ($urandom_range(2)) t.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            case ($urandom_range(2))
                1: t.push_back(CH_PLUS);
                2: t.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(2)) t.push_back(CH_ZERO);
            n = ($urandom_range(7) == 0) ? $urandom_range(16, 26) : $urandom_range(5);
            repeat (n) t.push_back(zeros ? CH_ZERO : 8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(1)) begin
                t.push_back(CH_POINT);
                n = ($urandom_range(9) == 0) ? $urandom_range(16, 26) : $urandom_range(5);
                repeat (n) t.push_back(zeros ? CH_ZERO : 8'(CH_ZERO + $urandom_range(9)));
            end
            if ($urandom_range(1)) begin
                t.push_back($urandom_range(1) ? CH_E : (CH_E ^ CH_LOWER_BIT));
                case ($urandom_range(2))
                    1: t.push_back(CH_PLUS);
                    2: t.push_back(CH_MINUS);
                    default: ;
                endcase
                n = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(3);
                repeat (n) t.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
            if (t.size() != 0 && $urandom_range(9) == 0)
                t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(4) == 0) t.push_back(8'($urandom_range(255)));
            if ($urandom_range(7) == 0) t.push_back(CH_NUL);
            if ($urandom_range(5) == 0)
                repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(255)));
            if (t.size() > 1 && $urandom_range(9) == 0) t = t[0:$urandom_range(t.size() - 2)];
        end
        if (t.size() == 0) t.push_back(8'(CH_ZERO + $urandom_range(9)));
        queue_text(t);
    endtask

    always @(posedge i_clk) begin : monitor_proc
        t_result want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            np_scan(i_char_code);
            if (i_end_of_text) records_due.push_back(np_record());
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (records_due.size() == 0) begin
                $display("%0t ns: unexpected result item with no record pending", $time);
                mismatches++;
            end else begin
                want = records_due.pop_front();
                report_field("negative", want.negative, o_negative);
                report_field("digit_count", want.digit_count, o_digit_count);
                report_field("digits_first_ten", want.digits_first_ten, o_digits_first_ten);
                report_field("digits_last_ten", want.digits_last_ten, o_digits_last_ten);
                report_field("power_of_ten", want.power_of_ten, o_power_of_ten);
                report_field("accepted_length", want.accepted_length, o_accepted_length);
                report_field("not_a_number", want.not_a_number, o_not_a_number);
                report_field("reached_end", want.reached_end, o_reached_end);
                report_field("digits_overflow", want.digits_overflow, o_digits_overflow);
                report_field("exponent_clipped", want.exponent_clipped, o_exponent_clipped);
            end
        end
    end

    always @(negedge i_clk) begin : driver_proc
        t_send_entry e;
        logic        offer;
        logic        stall;
        int          idle;
        offer = i_in_valid && !in_taken;
        stall = 1'b0;
        idle  = (pace == PACE_SINK_SLOW) ? 11 : (pace == PACE_SOURCE_SLOW) ? 65 : 0;
        if (i_rst_n && !offer) begin
            while (!stall && text_queue.size() != 0 && text_queue[0].kind != SEND_CHAR) begin
                case (text_queue[0].kind)
                    SEND_MODE: begin
                        pace <= t_pace'(text_queue[0].code[1:0]);
                        void'(text_queue.pop_front());
                    end
                    SEND_HOLD: begin
                        hold_token <= hold_token + 8'd1;
                        void'(text_queue.pop_front());
                    end
                    SEND_DRAIN: begin
                        if (records_due.size() == 0) void'(text_queue.pop_front());
                        else stall = 1'b1;
                    end
                    default: stall = 1'b1;
                endcase
            end
            if (!stall && text_queue.size() != 0 && $urandom_range(99) >= idle) begin
                e = text_queue.pop_front();
                i_char_code   <= e.code;
                i_end_of_text <= e.last;
                offer = 1'b1;
            end
        end
        i_in_valid <= offer;
    end

    always @(negedge i_clk) begin : sink_proc
        int idle;
        idle = (pace == PACE_SINK_SLOW) ? 65 : (pace == PACE_SOURCE_SLOW) ? 11 : 0;
        if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n && ($urandom_range(99) >= idle);
        end
    end

    initial begin : watchdog_proc
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus_proc
        logic [7:0] t[$];
        int         m;
        int         start;
        logic       hold_queued;
        np_clear();

        queue_string("\t-0.0");
        queue_string("1.5e-3");
        queue_string("7E");
        queue_string("9e+");
        queue_string("+x");
        queue_string(".5");
        queue_string("4z9");
        t = {8'hFF};
        queue_text(t);
        t = {8'h00};
        queue_text(t);
        queue_marker(SEND_DRAIN, 8'd0);

        start = chars_queued;
        for (m = 0; m < 3; m++) begin
            queue_marker(SEND_MODE, 8'(m));
            hold_queued = (m == 1);
            while (chars_queued < start + (m + 1) * RANDOM_CHARS / 3) begin
                queue_random_text();
                if (!hold_queued && chars_queued > start + m * RANDOM_CHARS / 3 + 60) begin
                    queue_marker(SEND_HOLD, 8'd0);
                    hold_queued = 1'b1;
                end
            end
            queue_marker(SEND_DRAIN, 8'd0);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (records_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
